[rtl/core/msc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Types, register indexes and reset values for the magnetometer sample
// correction pipeline.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int COUNT_W  = 20;
    localparam int GAIN_W   = 16;
    localparam int NORM_W   = 16;
    localparam int FIELD_W  = 24;
    localparam int FRAC_W   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int READY_BIT     = 6;
    localparam int SELF_TEST_BIT = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5,
        REG_NORM_MIN = 3'd6,
        REG_NORM_MAX = 3'd7
    } cfg_index_t;

    localparam logic signed [COUNT_W-1:0] OFFSET_X_RESET = -20'sd4169;
    localparam logic signed [COUNT_W-1:0] OFFSET_Y_RESET = 20'sd1447;
    localparam logic signed [COUNT_W-1:0] OFFSET_Z_RESET = -20'sd5135;
    localparam logic [GAIN_W-1:0] GAIN_X_RESET   = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_Y_RESET   = 16'd17515;
    localparam logic [GAIN_W-1:0] GAIN_Z_RESET   = 16'd15385;
    localparam logic [NORM_W-1:0] NORM_MIN_RESET = 16'd3200;
    localparam logic [NORM_W-1:0] NORM_MAX_RESET = 16'd12800;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] x_high;
        logic [7:0] x_mid;
        logic [7:0] y_high;
        logic [7:0] y_mid;
        logic [7:0] z_high;
        logic [7:0] z_mid;
        logic [7:0] x_extra;
        logic [7:0] y_extra;
        logic [7:0] z_extra;
    } in_item_t;

    typedef struct packed {
        logic                        sample_ok;
        logic                        self_test_flag;
        logic signed [COUNT_W-1:0]   raw_x;
        logic signed [COUNT_W-1:0]   raw_y;
        logic signed [COUNT_W-1:0]   raw_z;
        logic signed [FIELD_W-1:0]   field_x;
        logic signed [FIELD_W-1:0]   field_y;
        logic signed [FIELD_W-1:0]   field_z;
        logic                        healthy;
    } out_item_t;

    // Clamp a value one bit wider than a field into the field range.
    function automatic logic signed [FIELD_W-1:0] sat_field(
        input logic signed [FIELD_W:0] v
    );
        logic signed [FIELD_W-1:0] r;
        if (v[FIELD_W] != v[FIELD_W-1])
            r = v[FIELD_W] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
        else
            r = v[FIELD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/msc_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_axis
// One axis datapath: rebuild the signed count, subtract the hard-iron offset,
// scale by the soft-iron gain, shift, optionally negate and saturate.
// Three register stages; the field and raw count come out aligned.
// ----------------------------------------------------------------------------
module msc_axis
(
    input  wire logic                                 clk,
    input  wire logic [7:0]                           count_high,
    input  wire logic [7:0]                           count_mid,
    input  wire logic [7:0]                           count_extra,
    input  wire logic signed [msc_pkg::COUNT_W-1:0]   offset,
    input  wire logic [msc_pkg::GAIN_W-1:0]           gain,
    input  wire logic                                 negate,
    output logic signed [msc_pkg::COUNT_W-1:0]        raw,
    output logic signed [msc_pkg::FIELD_W-1:0]        field
);
    import msc_pkg::*;

    localparam int DIFF_W = COUNT_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    logic signed [COUNT_W-1:0] raw_in;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [COUNT_W-1:0] raw_s1_reg, raw_s2_reg, raw_s3_reg;
    logic signed [DIFF_W-1:0]  diff_s1_reg;
    logic signed [PROD_W-1:0]  prod_s2_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [FIELD_W-1:0] quot;
    logic signed [FIELD_W:0]   neg_quot;
    logic signed [FIELD_W-1:0] field_next;
    logic signed [FIELD_W-1:0] field_s3_reg;

    // Offset binary to two's complement: flip the top bit.
    assign raw_in    = {~count_high[7], count_high[6:0], count_mid, count_extra[7:4]};
    assign diff_next = {raw_in[COUNT_W-1], raw_in} - {offset[COUNT_W-1], offset};
    assign prod_next = {{(PROD_W-DIFF_W){diff_s1_reg[DIFF_W-1]}}, diff_s1_reg}
                     * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});

    // Arithmetic shift floors toward minus infinity.
    assign quot     = prod_s2_reg[FRAC_W+FIELD_W-1:FRAC_W];
    assign neg_quot = -{quot[FIELD_W-1], quot};
    assign field_next = negate ? sat_field(neg_quot)
                               : sat_field({quot[FIELD_W-1], quot});

    always_ff @(posedge clk)
    begin
        raw_s1_reg   <= raw_in;
        diff_s1_reg  <= diff_next;
        raw_s2_reg   <= raw_s1_reg;
        prod_s2_reg  <= prod_next;
        raw_s3_reg   <= raw_s2_reg;
        field_s3_reg <= field_next;
    end

    assign raw   = raw_s3_reg;
    assign field = field_s3_reg;

endmodule
`default_nettype wire

[rtl/core/magnetometer_sample_correct.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_sample_correct
// Hard-iron and soft-iron correction of three-axis magnetometer samples with
// a squared-norm health check.
// Pipeline: five register stages; done pulses in the same cycle as its result.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Per-axis multiply, then three parallel squarers, then one add and compare.
// Reset: pipeline valid bits clear, configuration registers return to their reset values.
// ----------------------------------------------------------------------------
module magnetometer_sample_correct
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire msc_pkg::in_item_t                   sample,
    output logic                                     done,
    output msc_pkg::out_item_t                       result,
    input  wire logic                                cfg_write,
    input  wire logic [msc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [msc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import msc_pkg::*;

    localparam int SQ_W  = 2 * FIELD_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int NSQ_W = 2 * NORM_W;
    localparam int AXIS_STAGES = 3;

    logic signed [COUNT_W-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [GAIN_W-1:0]         gain_x_reg, gain_y_reg, gain_z_reg;
    logic [NORM_W-1:0]         norm_min_reg, norm_max_reg;

    logic                      accept;
    logic [AXIS_STAGES-1:0]    valid_reg;
    logic [AXIS_STAGES-1:0]    ok_reg;
    logic [AXIS_STAGES-1:0]    st_reg;

    logic signed [COUNT_W-1:0] raw_x, raw_y, raw_z;
    logic signed [FIELD_W-1:0] field_x, field_y, field_z;

    logic                      valid_s4_reg, ok_s4_reg, st_s4_reg;
    logic signed [COUNT_W-1:0] raw_x_s4_reg, raw_y_s4_reg, raw_z_s4_reg;
    logic signed [FIELD_W-1:0] field_x_s4_reg, field_y_s4_reg, field_z_s4_reg;
    logic signed [SQ_W-1:0]    sq_x_s4_reg, sq_y_s4_reg, sq_z_s4_reg;
    logic [NSQ_W-1:0]          lo_sq_reg, hi_sq_reg;

    logic [SUM_W-1:0]          norm_sq;
    logic                      healthy_next;
    out_item_t                 result_next;
    logic                      done_reg;
    out_item_t                 result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RESET;
            offset_y_reg <= OFFSET_Y_RESET;
            offset_z_reg <= OFFSET_Z_RESET;
            gain_x_reg   <= GAIN_X_RESET;
            gain_y_reg   <= GAIN_Y_RESET;
            gain_z_reg   <= GAIN_Z_RESET;
            norm_min_reg <= NORM_MIN_RESET;
            norm_max_reg <= NORM_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_OFFSET_X: offset_x_reg <= cfg_data[COUNT_W-1:0];
                REG_OFFSET_Y: offset_y_reg <= cfg_data[COUNT_W-1:0];
                REG_OFFSET_Z: offset_z_reg <= cfg_data[COUNT_W-1:0];
                REG_GAIN_X:   gain_x_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:   gain_y_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_Z:   gain_z_reg   <= cfg_data[GAIN_W-1:0];
                REG_NORM_MIN: norm_min_reg <= cfg_data[NORM_W-1:0];
                REG_NORM_MAX: norm_max_reg <= cfg_data[NORM_W-1:0];
                default: ;
            endcase
        end
    end

    // Threshold squares follow the registers in the next cycle.
    always_ff @(posedge clk)
    begin
        lo_sq_reg <= norm_min_reg * norm_min_reg;
        hi_sq_reg <= norm_max_reg * norm_max_reg;
    end

    msc_axis u_axis_x
    (
        .clk         (clk),
        .count_high  (sample.x_high),
        .count_mid   (sample.x_mid),
        .count_extra (sample.x_extra),
        .offset      (offset_x_reg),
        .gain        (gain_x_reg),
        .negate      (1'b1),
        .raw         (raw_x),
        .field       (field_x)
    );

    msc_axis u_axis_y
    (
        .clk         (clk),
        .count_high  (sample.y_high),
        .count_mid   (sample.y_mid),
        .count_extra (sample.y_extra),
        .offset      (offset_y_reg),
        .gain        (gain_y_reg),
        .negate      (1'b0),
        .raw         (raw_y),
        .field       (field_y)
    );

    msc_axis u_axis_z
    (
        .clk         (clk),
        .count_high  (sample.z_high),
        .count_mid   (sample.z_mid),
        .count_extra (sample.z_extra),
        .offset      (offset_z_reg),
        .gain        (gain_z_reg),
        .negate      (1'b1),
        .raw         (raw_z),
        .field       (field_z)
    );

    // Valid bits travel alongside the axis stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_s4_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_reg    <= {valid_reg[AXIS_STAGES-2:0], accept};
            valid_s4_reg <= valid_reg[AXIS_STAGES-1];
            done_reg     <= valid_s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= {ok_reg[AXIS_STAGES-2:0], sample.status_byte[READY_BIT]};
        st_reg <= {st_reg[AXIS_STAGES-2:0], sample.status_byte[SELF_TEST_BIT]};

        ok_s4_reg      <= ok_reg[AXIS_STAGES-1];
        st_s4_reg      <= st_reg[AXIS_STAGES-1];
        raw_x_s4_reg   <= raw_x;
        raw_y_s4_reg   <= raw_y;
        raw_z_s4_reg   <= raw_z;
        field_x_s4_reg <= field_x;
        field_y_s4_reg <= field_y;
        field_z_s4_reg <= field_z;
        sq_x_s4_reg    <= SQ_W'(field_x) * SQ_W'(field_x);
        sq_y_s4_reg    <= SQ_W'(field_y) * SQ_W'(field_y);
        sq_z_s4_reg    <= SQ_W'(field_z) * SQ_W'(field_z);
    end

    assign norm_sq = SUM_W'($unsigned(sq_x_s4_reg)) + SUM_W'($unsigned(sq_y_s4_reg))
                   + SUM_W'($unsigned(sq_z_s4_reg));
    assign healthy_next = (norm_sq > SUM_W'(lo_sq_reg)) && (norm_sq < SUM_W'(hi_sq_reg));

    // Zero every field when the data-ready bit is clear.
    always_comb
    begin
        result_next = '0;
        if (ok_s4_reg)
        begin
            result_next.sample_ok      = 1'b1;
            result_next.self_test_flag = st_s4_reg;
            result_next.raw_x          = raw_x_s4_reg;
            result_next.raw_y          = raw_y_s4_reg;
            result_next.raw_z          = raw_z_s4_reg;
            result_next.field_x        = field_x_s4_reg;
            result_next.field_y        = field_y_s4_reg;
            result_next.field_z        = field_z_s4_reg;
            result_next.healthy        = healthy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
